FILE: sv/fsb_pkg.sv
// Shared types and constants for the flat bitstream serializer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package fsb_pkg;

    localparam int WORD_BITS   = 64;
    localparam int LENGTH_BITS = 32;
    localparam int GROUP_BITS  = 7;

    localparam logic [7:0] BLOCK_MAX = 8'd255;
    localparam logic [3:0] MAX_BITS  = 4'd8;

    // Command codes
    localparam logic [2:0] CMD_BITS      = 3'd0;
    localparam logic [2:0] CMD_WORD      = 3'd1;
    localparam logic [2:0] CMD_FILLER    = 3'd2;
    localparam logic [2:0] CMD_STR_START = 3'd3;
    localparam logic [2:0] CMD_STR_DATA  = 3'd4;
    localparam logic [2:0] CMD_FINISH    = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_SEQ   = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  bit_field;
        logic [3:0]  bit_count;
        logic [63:0] word_value;
        logic [31:0] string_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic tail;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
        logic more;
        logic tail;
    } dp_status_t;

endpackage

FILE: sv/fsb_datapath.sv
// Datapath of the flat bitstream serializer: bit packer, string counters, result register.
// Depends on fsb_pkg; driven by commands from fsb_ctrl.
module fsb_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  fsb_pkg::item_t     item,
    input  fsb_pkg::ctl_cmd_t  ctl,
    output fsb_pkg::dp_status_t sts,
    input  logic               result_ready,
    output logic               result_valid,
    output fsb_pkg::result_t   result
);

    logic [7:0]                      partial_reg, partial_next;
    logic [2:0]                      fill_reg, fill_next;
    logic [fsb_pkg::LENGTH_BITS-1:0] left_reg, left_next;
    logic [7:0]                      block_reg, block_next;
    logic                            open_reg, open_next;
    logic                            out_valid_reg, out_valid_next;
    fsb_pkg::item_t                  item_reg;
    logic [fsb_pkg::WORD_BITS-1:0]   word_reg, word_next;
    fsb_pkg::result_t                out_reg, res;

    logic                            err_seq;
    logic [fsb_pkg::WORD_BITS-1:0]   word_rest;
    logic [7:0]                      group_byte;
    logic [7:0]                      aligned;
    logic [15:0]                     merged;
    logic [3:0]                      total;
    logic [fsb_pkg::LENGTH_BITS-1:0] left_dec;
    logic [fsb_pkg::LENGTH_BITS-1:0] tail_len;
    logic [7:0]                      block_dec;
    logic [7:0]                      header;
    logic                            head_tail;
    logic                            head_more;

    assign word_rest  = word_reg >> fsb_pkg::GROUP_BITS;
    assign group_byte = {(word_rest != '0), word_reg[fsb_pkg::GROUP_BITS-1:0]};
    assign aligned    = (item_reg.cmd == fsb_pkg::CMD_WORD) ? group_byte
                      : 8'(item_reg.bit_field << (4'd8 - item_reg.bit_count));
    assign merged     = {partial_reg, 8'h00} | ({aligned, 8'h00} >> fill_reg);
    assign total      = {1'b0, fill_reg} + item_reg.bit_count;
    assign left_dec   = left_reg - fsb_pkg::LENGTH_BITS'(1);
    assign block_dec  = block_reg - 8'd1;
    assign tail_len   = (item_reg.cmd == fsb_pkg::CMD_STR_START)
                      ? item_reg.string_length[fsb_pkg::LENGTH_BITS-1:0] : left_reg;
    assign header     = (tail_len > fsb_pkg::LENGTH_BITS'(fsb_pkg::BLOCK_MAX))
                      ? fsb_pkg::BLOCK_MAX : tail_len[7:0];
    assign err_seq    = (item_reg.cmd > fsb_pkg::CMD_FINISH)
                      || (open_reg && item_reg.cmd != fsb_pkg::CMD_STR_DATA)
                      || (!open_reg && item_reg.cmd == fsb_pkg::CMD_STR_DATA);

    always_comb
    begin
        partial_next = partial_reg;
        fill_next    = fill_reg;
        left_next    = left_reg;
        block_next   = block_reg;
        open_next    = open_reg;
        word_next    = word_reg;
        res          = '0;
        head_tail    = 1'b0;
        head_more    = 1'b0;
        if (ctl.tail)
        begin
            // Terminator for an empty remainder, block header otherwise
            res.byte_valid = 1'b1;
            left_next      = tail_len;
            if (tail_len == '0)
            begin
                open_next  = 1'b0;
                block_next = 8'd0;
            end
            else
            begin
                res.out_byte = header;
                open_next    = 1'b1;
                block_next   = header;
            end
        end
        else if (err_seq)
        begin
            res.status = fsb_pkg::ST_SEQ;
        end
        else
        begin
            unique case (item_reg.cmd) inside
                fsb_pkg::CMD_BITS:
                begin
                    if (item_reg.bit_count > fsb_pkg::MAX_BITS)
                    begin
                        res.status = fsb_pkg::ST_COUNT;
                    end
                    else if (total >= 4'd8)
                    begin
                        res.byte_valid = 1'b1;
                        res.out_byte   = merged[15:8];
                        partial_next   = merged[7:0];
                        fill_next      = total[2:0];
                    end
                    else
                    begin
                        partial_next = merged[15:8];
                        fill_next    = total[2:0];
                    end
                end
                fsb_pkg::CMD_WORD:
                begin
                    res.byte_valid = 1'b1;
                    res.out_byte   = merged[15:8];
                    partial_next   = merged[7:0];
                    word_next      = word_rest;
                    head_more      = (word_rest != '0);
                end
                fsb_pkg::CMD_FILLER, fsb_pkg::CMD_STR_START:
                begin
                    res.byte_valid = 1'b1;
                    res.out_byte   = partial_reg | 8'h01;
                    partial_next   = 8'h00;
                    fill_next      = 3'd0;
                    head_tail      = (item_reg.cmd == fsb_pkg::CMD_STR_START);
                end
                fsb_pkg::CMD_STR_DATA:
                begin
                    res.byte_valid = 1'b1;
                    res.out_byte   = item_reg.data_byte;
                    left_next      = left_dec;
                    block_next     = block_dec;
                    head_tail      = (left_dec == '0) || (block_dec == 8'd0);
                end
                fsb_pkg::CMD_FINISH:
                begin
                    res.byte_valid = (fill_reg != 3'd0);
                    res.out_byte   = (fill_reg != 3'd0) ? partial_reg : 8'h00;
                    partial_next   = 8'h00;
                    fill_next      = 3'd0;
                end
                default:
                begin
                end
            endcase
        end
        res.last = ctl.tail || (!head_tail && !head_more);
    end

    assign out_valid_next = ctl.step || (out_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= 8'h00;
            fill_reg      <= 3'd0;
            left_reg      <= '0;
            block_reg     <= 8'd0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctl.step)
            begin
                partial_reg <= partial_next;
                fill_reg    <= fill_next;
                left_reg    <= left_next;
                block_reg   <= block_next;
                open_reg    <= open_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= item;
            word_reg <= item.word_value[fsb_pkg::WORD_BITS-1:0];
        end
        else if (ctl.step)
        begin
            word_reg <= word_next;
        end
        if (ctl.step)
        begin
            out_reg <= res;
        end
    end

    assign sts.slot_free = !out_valid_reg || result_ready;
    assign sts.more      = head_more;
    assign sts.tail      = head_tail;
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;

endmodule

FILE: sv/fsb_ctrl.sv
// Controller of the flat bitstream serializer: sequences the results of one item.
// Depends on fsb_pkg; drives fsb_datapath through ctl_cmd_t.
module fsb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  fsb_pkg::dp_status_t sts,
    output fsb_pkg::ctl_cmd_t   ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BODY,
        S_TAIL
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_BODY;
                end
            end
            S_BODY:
            begin
                // Stay here while word groups remain or while the result register is not free
                if (sts.slot_free)
                begin
                    ctl.step = 1'b1;
                    if (sts.tail)
                    begin
                        state_next = S_TAIL;
                    end
                    else if (!sts.more)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_TAIL:
            begin
                if (sts.slot_free)
                begin
                    ctl.step   = 1'b1;
                    ctl.tail   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

endmodule

FILE: sv/flat_bitstream_serializer.sv
// Top level of the flat bitstream serializer: controller plus datapath.
// Depends on fsb_pkg, fsb_ctrl and fsb_datapath.
//
// Packs bits MSB first into whole bytes and returns one result per output byte, each
// carrying the byte, a byte-valid flag, a status code and a last flag on the final
// result of the item. An item that sends no byte (an error, a short bit append, a
// finish with nothing pending) returns a single result with byte_valid low. Items are
// handled one at a time: an item is taken while the controller is idle and then its
// results are written into the result register at one per cycle while the register is
// free. A bit append or an error gives one result, a string start or a data byte that
// closes a block gives two, and a 64-bit word up to ten (ten groups). The single result
// register sets that pace; a stalled result holds the sequence until the downstream
// side takes the transfer.
module flat_bitstream_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  fsb_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output fsb_pkg::result_t result
);

    fsb_pkg::ctl_cmd_t   ctl;
    fsb_pkg::dp_status_t sts;

    // Sequence the results of each item
    fsb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    // Hold packer and string state, build each result
    fsb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctl          (ctl),
        .sts          (sts),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    // An accepted item keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input open right after an accepted transfer");

    // Never overwrite a result that has not been taken
    a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> sts.slot_free)
        else $error("result register overwritten");

    // A result without a byte is always the only result of its item
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_valid |-> result.last)
        else $error("empty result not marked last");

    // Error results never carry a byte
    a_err_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != fsb_pkg::ST_OK |-> !result.byte_valid)
        else $error("error result carries a byte");
`endif

endmodule
